### sv/limit_order_book_heap_assert.svh
// assertion macros for the order book heap
// used by the top level only, no other dependencies
`ifndef LIMIT_ORDER_BOOK_HEAP_ASSERT_SVH
`define LIMIT_ORDER_BOOK_HEAP_ASSERT_SVH
`ifndef SYNTH
`define LOBH_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("order book assertion failed");
`define LOBH_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("order book assertion failed");
`else
`define LOBH_ASSERT(lbl, clk, rstn, prop)
`define LOBH_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

### sv/lobh_pkg.sv
// shared types, constants and the ranking function of the order book heap
// no dependencies
package lobh_pkg;

    localparam int TREE_LEVELS_DEF   = 10;
    localparam int BOOK_CAPACITY_DEF = 1024;
    localparam int QUEUE_DEPTH       = 2;
    localparam logic [31:0] EMPTY_ASK_RESET = 32'd1000000;

    // input kind codes
    localparam logic [2:0] KIND_ADD_BID = 3'd0;
    localparam logic [2:0] KIND_ADD_ASK = 3'd1;
    localparam logic [2:0] KIND_REM_BID = 3'd2;
    localparam logic [2:0] KIND_REM_ASK = 3'd3;

    typedef struct packed {
        logic [31:0] price;
        logic [7:0]  qty;
        logic [31:0] id;
    } t_slot;

    // classified item travelling from front to back
    typedef struct packed {
        logic        is_rem;
        logic        is_ask;
        t_slot       item;
        logic [63:0] ts;
        logic [63:0] meta;
    } t_cmd;

    typedef struct packed {
        logic clearing;
        logic busy;
    } t_eng_status;

    // true when a ranks strictly above c on the given side
    function automatic logic ranks_above(input logic is_ask, input t_slot a, input t_slot c);
        logic r;
        if (c.id == 32'd0) begin
            r = 1'b1;
        end else if (a.id == 32'd0) begin
            r = 1'b0;
        end else if (a.price == c.price) begin
            r = (a.id < c.id);
        end else if (is_ask) begin
            r = (a.price < c.price);
        end else begin
            r = (a.price > c.price);
        end
        return r;
    endfunction

endpackage

### sv/lobh_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module lobh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/lobh_front.sv
// front end: accepts input items, drops unused kinds, classifies the rest
// depends on lobh_pkg
module lobh_front
    import lobh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_hold,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_kind,
    input  logic [31:0] i_price,
    input  logic [7:0]  i_quantity,
    input  logic [31:0] i_order_id,
    input  logic [63:0] i_timestamp,
    input  logic [63:0] i_meta,
    output logic        o_push,
    output t_cmd        o_cmd,
    input  logic        i_q_ready
);

    logic r_valid, n_valid;
    t_cmd r_cmd, n_cmd;
    logic accept, kind_ok;

    assign o_ready = !i_hold && (!r_valid || i_q_ready);
    assign accept  = i_valid && o_ready;

    // only the four book kinds make it into the queue
    always_comb begin
        kind_ok = (i_kind inside {KIND_ADD_BID, KIND_ADD_ASK, KIND_REM_BID, KIND_REM_ASK});
    end

    // stage register next state
    always_comb begin
        n_valid = r_valid && !i_q_ready;
        n_cmd   = r_cmd;
        if (accept && kind_ok) begin
            n_valid           = 1'b1;
            n_cmd.is_rem      = i_kind[1];
            n_cmd.is_ask      = i_kind[0];
            n_cmd.item.price  = i_price;
            n_cmd.item.qty    = i_quantity;
            n_cmd.item.id     = i_order_id;
            n_cmd.ts          = i_timestamp;
            n_cmd.meta        = i_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

    assign o_push = r_valid;
    assign o_cmd  = r_cmd;

endmodule

### sv/lobh_queue.sv
// short queue of classified items between front and back
// depends on lobh_pkg
module lobh_queue
    import lobh_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_data,
    input  logic i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

### sv/lobh_engine.sv
// back end: walks the heaps one level at a time and registers the result
// depends on lobh_pkg and lobh_ram
module lobh_engine
    import lobh_pkg::*;
#(
    parameter int TREE_LEVELS   = TREE_LEVELS_DEF,
    parameter int BOOK_CAPACITY = BOOK_CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_empty_ask_price,
    input  logic        i_q_valid,
    input  t_cmd        i_q_data,
    output logic        o_q_pop,
    output t_eng_status o_status,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_bid_valid,
    output logic [31:0] o_bid_price,
    output logic [7:0]  o_bid_quantity,
    output logic [31:0] o_bid_id,
    output logic        o_ask_valid,
    output logic [31:0] o_ask_price,
    output logic [7:0]  o_ask_quantity,
    output logic [31:0] o_ask_id,
    output logic [63:0] o_timestamp_out,
    output logic [63:0] o_meta_out
);

    localparam int AW = $clog2(BOOK_CAPACITY);
    localparam int CW = $clog2(BOOK_CAPACITY + 1);
    localparam int LW = $clog2(TREE_LEVELS);
    localparam int PW = TREE_LEVELS - 1;
    localparam int FW = TREE_LEVELS;
    localparam int SW = $bits(t_slot);
    localparam int HEAP_LIMIT = ((BOOK_CAPACITY - 1) < ((1 << TREE_LEVELS) - 1)) ?
                                (BOOK_CAPACITY - 1) : ((1 << TREE_LEVELS) - 1);

    typedef enum logic [11:0] {
        S_CLEAR = 12'b000000000001,
        S_IDLE  = 12'b000000000010,
        S_HOLE  = 12'b000000000100,
        S_ARD   = 12'b000000001000,
        S_ACMP  = 12'b000000010000,
        S_RTOP  = 12'b000000100000,
        S_PL    = 12'b000001000000,
        S_PR    = 12'b000010000000,
        S_PCMP  = 12'b000100000000,
        S_ROOT  = 12'b001000000000,
        S_EMIT  = 12'b010000000000,
        S_SPARE = 12'b100000000000
    } t_state;

    typedef struct packed {
        logic        bid_valid;
        t_slot       bid;
        logic        ask_valid;
        t_slot       ask;
        logic [63:0] ts;
        logic [63:0] meta;
    } t_result;

    t_state        r_state, n_state;
    t_cmd          r_cmd, n_cmd;
    t_slot         r_item, n_item;
    logic [LW-1:0] r_l, n_l, r_i, n_i;
    logic [PW-1:0] r_idx, n_idx, r_path, n_path;
    logic [CW-1:0] r_count [2];
    logic [CW-1:0] n_count [2];
    logic [CW-1:0] r_holes [2];
    logic [CW-1:0] n_holes [2];
    logic [AW-1:0] r_clr;
    logic          r_rd_ok;
    logic          r_out_valid, n_out_valid;
    t_result       r_out, n_out;

    // slot access request
    logic          wr_en;
    logic [LW-1:0] wr_l, rd_l;
    logic [PW-1:0] wr_idx, rd_idx;
    t_slot         wr_data;
    logic [FW-1:0] wr_flat, rd_flat;
    logic          wr_ok, rd_ok;

    // hole stack access
    logic          h_we;
    logic [AW-1:0] h_waddr, h_raddr;
    logic [PW-1:0] h_wdata;

    logic [SW-1:0] bid_rdata, ask_rdata;
    logic [PW-1:0] bid_hdata, ask_hdata;
    t_slot         rd_side;
    logic          clearing;
    logic          s;
    logic [CW-1:0] cnt;
    int            lv;
    t_slot         cur, top;
    logic          off;

    function automatic logic [FW-1:0] flat_of(input logic [LW-1:0] l, input logic [PW-1:0] idx);
        return (FW'(1) << l) - FW'(1) + FW'(idx);
    endfunction

    assign clearing = (r_state == S_CLEAR);
    assign wr_flat  = flat_of(wr_l, wr_idx);
    assign rd_flat  = flat_of(rd_l, rd_idx);
    assign wr_ok    = wr_en && (32'(wr_flat) < 32'(BOOK_CAPACITY));
    assign rd_ok    = (32'(rd_flat) < 32'(BOOK_CAPACITY));
    assign rd_side  = !r_rd_ok ? t_slot'('0) : (r_cmd.is_ask ? t_slot'(ask_rdata) :
                                                                t_slot'(bid_rdata));

    // heap slot stores, one per side
    lobh_ram #(.WIDTH(SW), .DEPTH(BOOK_CAPACITY)) u_bid_ram (
        .i_clk   (i_clk),
        .i_we    (clearing || (wr_ok && !r_cmd.is_ask)),
        .i_waddr (clearing ? r_clr : AW'(wr_flat)),
        .i_wdata (clearing ? '0 : SW'(wr_data)),
        .i_raddr (AW'(rd_flat)),
        .o_rdata (bid_rdata)
    );

    lobh_ram #(.WIDTH(SW), .DEPTH(BOOK_CAPACITY)) u_ask_ram (
        .i_clk   (i_clk),
        .i_we    (clearing || (wr_ok && r_cmd.is_ask)),
        .i_waddr (clearing ? r_clr : AW'(wr_flat)),
        .i_wdata (clearing ? '0 : SW'(wr_data)),
        .i_raddr (AW'(rd_flat)),
        .o_rdata (ask_rdata)
    );

    // hole stacks: leaf index only, the level is always the leaf level
    lobh_ram #(.WIDTH(PW), .DEPTH(BOOK_CAPACITY)) u_bid_holes (
        .i_clk   (i_clk),
        .i_we    (h_we && !r_cmd.is_ask),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (h_raddr),
        .o_rdata (bid_hdata)
    );

    lobh_ram #(.WIDTH(PW), .DEPTH(BOOK_CAPACITY)) u_ask_holes (
        .i_clk   (i_clk),
        .i_we    (h_we && r_cmd.is_ask),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (h_raddr),
        .o_rdata (ask_hdata)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_item      = r_item;
        n_l         = r_l;
        n_i         = r_i;
        n_idx       = r_idx;
        n_path      = r_path;
        n_count     = r_count;
        n_holes     = r_holes;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        wr_en       = 1'b0;
        wr_l        = r_l;
        wr_idx      = r_idx;
        wr_data     = r_item;
        rd_l        = r_l;
        rd_idx      = r_idx;
        h_we        = 1'b0;
        h_waddr     = '0;
        h_wdata     = r_idx;
        o_q_pop     = 1'b0;
        s           = i_q_data.is_ask;
        h_raddr     = AW'(r_holes[s] - CW'(1));
        cnt         = r_count[s] + CW'(1);
        lv          = 0;
        cur         = rd_side;
        top         = rd_side;
        off         = 1'b0;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(BOOK_CAPACITY - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid && !r_out_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_data;
                    n_item  = i_q_data.item;
                    n_l     = '0;
                    n_idx   = '0;
                    if (!i_q_data.is_rem) begin
                        // add: pick the target slot and bump the count
                        n_count[s] = (32'(cnt) >= 32'(HEAP_LIMIT)) ? CW'(HEAP_LIMIT - 1) : cnt;
                        if (r_holes[s] != '0) begin
                            n_holes[s] = r_holes[s] - CW'(1);
                            n_state    = S_HOLE;
                        end else begin
                            for (int b = 0; b < CW; b++) begin
                                if (cnt[b]) begin
                                    lv = b;
                                end
                            end
                            if (lv > TREE_LEVELS - 1) begin
                                lv = TREE_LEVELS - 1;
                            end
                            n_i     = LW'(lv);
                            n_path  = PW'(cnt - (CW'(1) << lv));
                            n_state = S_ARD;
                        end
                    end else if (r_count[s] == '0) begin
                        n_state = S_ROOT;
                    end else begin
                        rd_l    = '0;
                        rd_idx  = '0;
                        n_state = S_RTOP;
                    end
                end
            end
            S_HOLE: begin
                n_path  = r_cmd.is_ask ? ask_hdata : bid_hdata;
                n_i     = LW'(TREE_LEVELS - 1);
                n_state = S_ARD;
            end
            S_ARD: begin
                if (r_i == '0) begin
                    wr_en   = 1'b1;
                    n_state = S_ROOT;
                end else begin
                    n_state = S_ACMP;
                end
            end
            S_ACMP: begin
                // swap in wherever the carried order beats the resident one
                if (ranks_above(r_cmd.is_ask, r_item, cur)) begin
                    wr_en  = 1'b1;
                    n_item = cur;
                end
                n_idx   = (r_idx << 1) | PW'((r_path >> (r_i - LW'(1))) & PW'(1));
                n_l     = r_l + LW'(1);
                n_i     = r_i - LW'(1);
                n_state = S_ARD;
            end
            S_RTOP: begin
                if (r_item.qty < top.qty) begin
                    // partial fill of the top order
                    wr_en       = 1'b1;
                    wr_l        = '0;
                    wr_idx      = '0;
                    wr_data     = top;
                    wr_data.qty = top.qty - r_item.qty;
                    n_state     = S_ROOT;
                end else begin
                    n_l     = '0;
                    n_idx   = '0;
                    n_state = S_PL;
                end
            end
            S_PL: begin
                if (r_l == LW'(TREE_LEVELS - 1)) begin
                    // leaf reached: vacate it and record the hole
                    wr_en         = 1'b1;
                    wr_data.price = r_cmd.is_ask ? i_empty_ask_price : 32'd0;
                    wr_data.qty   = '0;
                    wr_data.id    = '0;
                    if (32'(r_holes[r_cmd.is_ask]) < 32'(BOOK_CAPACITY)) begin
                        h_we    = 1'b1;
                        h_waddr = AW'(r_holes[r_cmd.is_ask]);
                        n_holes[r_cmd.is_ask] = r_holes[r_cmd.is_ask] + CW'(1);
                    end
                    n_count[r_cmd.is_ask] = r_count[r_cmd.is_ask] - CW'(1);
                    n_state = S_ROOT;
                end else begin
                    rd_l    = r_l + LW'(1);
                    rd_idx  = r_idx << 1;
                    n_state = S_PR;
                end
            end
            S_PR: begin
                n_item  = rd_side;
                rd_l    = r_l + LW'(1);
                rd_idx  = (r_idx << 1) | PW'(1);
                n_state = S_PCMP;
            end
            S_PCMP: begin
                // pull the better child up one level
                off     = !ranks_above(r_cmd.is_ask, r_item, cur);
                wr_en   = 1'b1;
                wr_data = off ? cur : r_item;
                n_idx   = (r_idx << 1) | PW'(off);
                n_l     = r_l + LW'(1);
                n_state = S_PL;
            end
            S_ROOT: begin
                rd_l    = '0;
                rd_idx  = '0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                n_out.ts   = r_cmd.ts;
                n_out.meta = r_cmd.meta;
                if (!r_cmd.is_rem) begin
                    n_out.bid_valid = 1'b1;
                    n_out.ask_valid = 1'b1;
                end else begin
                    n_out.bid_valid = !r_cmd.is_ask && (r_count[0] != '0);
                    n_out.ask_valid = r_cmd.is_ask && (r_count[1] != '0);
                end
                n_out.bid   = n_out.bid_valid ? t_slot'(bid_rdata) : t_slot'('0);
                n_out.ask   = n_out.ask_valid ? t_slot'(ask_rdata) : t_slot'('0);
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (r_state == S_ARD || r_state == S_ACMP) begin
            rd_l   = (r_state == S_ARD) ? r_l : rd_l;
            rd_idx = (r_state == S_ARD) ? r_idx : rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_count[0]  <= '0;
            r_count[1]  <= '0;
            r_holes[0]  <= '0;
            r_holes[1]  <= '0;
        end else begin
            r_state     <= n_state;
            r_clr       <= clearing ? r_clr + AW'(1) : r_clr;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            r_holes     <= n_holes;
        end
        r_cmd   <= n_cmd;
        r_item  <= n_item;
        r_l     <= n_l;
        r_i     <= n_i;
        r_idx   <= n_idx;
        r_path  <= n_path;
        r_rd_ok <= rd_ok;
        r_out   <= n_out;
    end

    assign o_status.clearing = clearing;
    assign o_status.busy     = !clearing && (r_state != S_IDLE);

    assign o_valid         = r_out_valid;
    assign o_bid_valid     = r_out.bid_valid;
    assign o_bid_price     = r_out.bid.price;
    assign o_bid_quantity  = r_out.bid.qty;
    assign o_bid_id        = r_out.bid.id;
    assign o_ask_valid     = r_out.ask_valid;
    assign o_ask_price     = r_out.ask.price;
    assign o_ask_quantity  = r_out.ask.qty;
    assign o_ask_id        = r_out.ask.id;
    assign o_timestamp_out = r_out.ts;
    assign o_meta_out      = r_out.meta;

endmodule

### sv/limit_order_book_heap.sv
// top level of the two-heap limit order book
// depends on lobh_pkg, lobh_front, lobh_queue, lobh_engine, assertion header
//
//  channel   handshake                    payload
//  input     i_valid / o_ready            i_kind i_price i_quantity i_order_id i_timestamp i_meta
//  result    o_valid / i_ready            o_bid_* o_ask_* o_timestamp_out o_meta_out
//  config    i_cfg_valid / o_cfg_ready    i_cfg_data (empty ask price)
//
// an add walks from the root down to its target level, through S_HOLE first when it
// reuses a hole; a pop that takes the whole top order walks down through S_PL, S_PR
// and S_PCMP per heap level, as each slot store has a single read port. after reset
// a clearing pass zeroes the slot stores while o_ready stays low. a two-entry queue
// lets input items queue up while the engine works or a result waits for i_ready.
`include "limit_order_book_heap_assert.svh"
module limit_order_book_heap
    import lobh_pkg::*;
#(
    parameter int TREE_LEVELS   = TREE_LEVELS_DEF,
    parameter int BOOK_CAPACITY = BOOK_CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_kind,
    input  logic [31:0] i_price,
    input  logic [7:0]  i_quantity,
    input  logic [31:0] i_order_id,
    input  logic [63:0] i_timestamp,
    input  logic [63:0] i_meta,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_bid_valid,
    output logic [31:0] o_bid_price,
    output logic [7:0]  o_bid_quantity,
    output logic [31:0] o_bid_id,
    output logic        o_ask_valid,
    output logic [31:0] o_ask_price,
    output logic [7:0]  o_ask_quantity,
    output logic [31:0] o_ask_id,
    output logic [63:0] o_timestamp_out,
    output logic [63:0] o_meta_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    logic        r_empty_ask_price_valid;
    logic [31:0] r_empty_ask_price;
    logic        push, q_ready, q_valid, q_pop;
    t_cmd        push_cmd, q_cmd;
    t_eng_status status;

    // configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty_ask_price       <= EMPTY_ASK_RESET;
            r_empty_ask_price_valid <= 1'b0;
        end else if (i_cfg_valid) begin
            r_empty_ask_price       <= i_cfg_data;
            r_empty_ask_price_valid <= 1'b1;
        end
    end

    lobh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hold      (status.clearing),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_price     (i_price),
        .i_quantity  (i_quantity),
        .i_order_id  (i_order_id),
        .i_timestamp (i_timestamp),
        .i_meta      (i_meta),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .i_q_ready   (q_ready)
    );

    lobh_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_cmd),
        .i_pop   (q_pop)
    );

    lobh_engine #(
        .TREE_LEVELS   (TREE_LEVELS),
        .BOOK_CAPACITY (BOOK_CAPACITY)
    ) u_engine (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_empty_ask_price (r_empty_ask_price),
        .i_q_valid         (q_valid),
        .i_q_data          (q_cmd),
        .o_q_pop           (q_pop),
        .o_status          (status),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_bid_valid       (o_bid_valid),
        .o_bid_price       (o_bid_price),
        .o_bid_quantity    (o_bid_quantity),
        .o_bid_id          (o_bid_id),
        .o_ask_valid       (o_ask_valid),
        .o_ask_price       (o_ask_price),
        .o_ask_quantity    (o_ask_quantity),
        .o_ask_id          (o_ask_id),
        .o_timestamp_out   (o_timestamp_out),
        .o_meta_out        (o_meta_out)
    );

    // checks
    `LOBH_ASSERT_NEVER(a_pop_empty_queue, i_clk, i_rst_n, q_pop && !q_valid)
    `LOBH_ASSERT(a_no_accept_clearing, i_clk, i_rst_n, status.clearing |-> !o_ready)
    `LOBH_ASSERT(a_result_from_engine, i_clk, i_rst_n, $rose(o_valid) |-> $past(status.busy))
    `LOBH_ASSERT(a_cfg_taken, i_clk, i_rst_n, i_cfg_valid |=> r_empty_ask_price_valid)

endmodule
